/* hdl/stc_pkg.sv */
// shared types, constants and helpers of the sorted triangle run coalescer
package stc_pkg;

    // field and register widths
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 17;
    localparam int MAT_W   = 16;
    localparam int TRI_W   = 15;
    localparam int CFG_W   = 17;
    localparam int CFG_I_W = 2;

    // indices per triangle
    localparam logic [CNT_W-1:0] TRI_INDICES = 17'd3;

    // divide by three through a reciprocal, exact for 17-bit operands
    localparam int                DIV3_SHIFT = 17;
    localparam logic [CNT_W-1:0]  DIV3_RECIP = 17'd43691;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // configuration register indices
    localparam logic [CFG_I_W-1:0] CFG_INDEX_TOTAL    = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_MATERIAL_COUNT = 2'd1;

    // one input entry
    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [CNT_W-1:0] index_count;
        logic [MAT_W-1:0] material;
        logic             end_of_list;
    } t_in_item;

    // one emitted draw
    typedef struct packed {
        logic [MAT_W-1:0] draw_material;
        logic [IDX_W-1:0] draw_first;
        logic [TRI_W-1:0] draw_triangles;
        logic             last_draw;
    } t_out_item;

    // classified entry handed from front to back
    typedef struct packed {
        logic             ok;
        logic             eol;
        logic [MAT_W-1:0] material;
        logic [IDX_W-1:0] first;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] stop;
    } t_cmd;

    // queue head as seen by the back
    typedef struct packed {
        logic avail;
        t_cmd cmd;
    } t_q_head;

    // a draw before its triangle count is worked out
    typedef struct packed {
        logic [MAT_W-1:0] material;
        logic [IDX_W-1:0] first;
        logic [CNT_W-1:0] length;
        logic             last;
    } t_draw;

    // truncated division of a run length by three
    function automatic logic [TRI_W-1:0] div3(input logic [CNT_W-1:0] x);
        logic [2*CNT_W-1:0] prod;
        prod = {{CNT_W{1'b0}}, x} * {{CNT_W{1'b0}}, DIV3_RECIP};
        return prod[DIV3_SHIFT +: TRI_W];
    endfunction

endpackage

/* hdl/stc_front.sv */
// front: configuration registers and entry validity classification
module stc_front
    import stc_pkg::*;
#(
    parameter int INDEX_CAPACITY = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_I_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  t_in_item           i_item,
    output t_cmd               o_cmd
);

    localparam logic [CFG_W-1:0] CAP = CFG_W'(INDEX_CAPACITY);

    logic [CFG_W-1:0] r_limit;
    logic [CFG_W-1:0] r_mat_count;
    logic [CFG_W:0]   stop_sum;

    // configuration writes, index total saturated at capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '0;
            r_mat_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INDEX_TOTAL:    r_limit     <= (i_cfg_data > CAP) ? CAP : i_cfg_data;
                CFG_MATERIAL_COUNT: r_mat_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // end of entry, wide enough never to wrap
    assign stop_sum = {2'b00, i_item.first_index} + {1'b0, i_item.index_count};

    // classify the entry
    always_comb begin
        o_cmd.ok       = (i_item.index_count >= TRI_INDICES)
                      && (stop_sum <= {1'b0, r_limit})
                      && ({1'b0, i_item.material} < r_mat_count);
        o_cmd.eol      = i_item.end_of_list;
        o_cmd.material = i_item.material;
        o_cmd.first    = i_item.first_index;
        o_cmd.count    = i_item.index_count;
        o_cmd.stop     = stop_sum[CFG_W-1:0];
    end

endmodule

/* hdl/stc_queue.sv */
// short command queue between front and back
module stc_queue
    import stc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    output t_q_head o_head,
    input  logic    i_pop
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill;
    logic               do_pop;

    assign do_pop = i_pop && (r_fill != '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && do_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full       = (r_fill == Q_CNT_W'(Q_DEPTH));
    assign o_head.avail = (r_fill != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

endmodule

/* hdl/stc_back.sv */
// back: run merging, draw emission and output registers
module stc_back
    import stc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    // run state
    logic             r_run_open;
    logic [MAT_W-1:0] r_run_mat;
    logic [IDX_W-1:0] r_run_start;
    logic [CNT_W-1:0] r_run_len;
    logic [CNT_W-1:0] r_run_end;
    logic             r_phase;

    // draw stage and output register
    logic             r_a_valid;
    t_draw            r_a_draw;
    logic             r_o_valid;
    t_out_item        r_o_data;

    logic             n_run_open;
    logic [MAT_W-1:0] n_run_mat;
    logic [IDX_W-1:0] n_run_start;
    logic [CNT_W-1:0] n_run_len;
    logic [CNT_W-1:0] n_run_end;
    logic             n_phase;

    t_cmd             cmd;
    logic             merge;
    logic [CNT_W-1:0] merged_len;
    logic             emit;
    t_draw            emit_draw;
    logic             pop;
    logic             b_take;
    logic             a_free;
    logic             step;

    assign cmd        = i_head.cmd;
    assign merge      = r_run_open && (cmd.material == r_run_mat)
                     && ({1'b0, cmd.first} == r_run_end);
    assign merged_len = r_run_len + cmd.count;
    assign b_take     = !r_o_valid || !i_stall;
    assign a_free     = !r_a_valid || b_take;

    // decide what the head entry does to the run
    always_comb begin
        n_run_open  = r_run_open;
        n_run_mat   = r_run_mat;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_run_end   = r_run_end;
        n_phase     = r_phase;
        emit        = 1'b0;
        pop         = 1'b1;
        emit_draw   = '{material: r_run_mat, first: r_run_start,
                        length: r_run_len, last: 1'b0};
        if (r_phase) begin
            // second draw of a breaking end-of-list entry
            emit           = 1'b1;
            emit_draw.last = 1'b1;
            n_run_open     = 1'b0;
            n_phase        = 1'b0;
        end else if (!cmd.ok) begin
            // skipped entry closes the open run
            emit           = r_run_open;
            emit_draw.last = cmd.eol;
            n_run_open     = 1'b0;
        end else if (merge) begin
            n_run_len = merged_len;
            n_run_end = cmd.stop;
            if (cmd.eol) begin
                emit             = 1'b1;
                emit_draw.length = merged_len;
                emit_draw.last   = 1'b1;
                n_run_open       = 1'b0;
            end
        end else begin
            // start a new run
            n_run_mat   = cmd.material;
            n_run_start = cmd.first;
            n_run_len   = cmd.count;
            n_run_end   = cmd.stop;
            n_run_open  = 1'b1;
            if (r_run_open) begin
                emit = 1'b1;
                if (cmd.eol) begin
                    n_phase = 1'b1;
                    pop     = 1'b0;
                end
            end else if (cmd.eol) begin
                emit       = 1'b1;
                emit_draw  = '{material: cmd.material, first: cmd.first,
                               length: cmd.count, last: 1'b1};
                n_run_open = 1'b0;
            end
        end
    end

    assign step  = i_head.avail && (a_free || !emit);
    assign o_pop = step && pop;

    // run state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open  <= 1'b0;
            r_run_mat   <= '0;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_run_end   <= '0;
            r_phase     <= 1'b0;
        end else if (step) begin
            r_run_open  <= n_run_open;
            r_run_mat   <= n_run_mat;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_run_end   <= n_run_end;
            r_phase     <= n_phase;
        end
    end

    // draw stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (step && emit) begin
            r_a_valid <= 1'b1;
        end else if (b_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_a_draw <= emit_draw;
        end
    end

    // output register with triangle count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_take) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take && r_a_valid) begin
            r_o_data.draw_material  <= r_a_draw.material;
            r_o_data.draw_first     <= r_a_draw.first;
            r_o_data.draw_triangles <= div3(r_a_draw.length);
            r_o_data.last_draw      <= r_a_draw.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

/* hdl/sorted_triangle_run_coalescer.sv */
// top level of the sorted triangle run coalescer
//
// Input channel: i_valid / o_stall carry one sorted entry in i_data; a transfer
// happens at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall carry one draw in o_data the same way. The write port
// (i_cfg_we, i_cfg_index, i_cfg_data) sets index total (0) and material count
// (1); other indices are ignored. Write it only while the block is idle.
// Each entry is classified on entry and placed in a four-deep command queue;
// the back end takes one entry per cycle against the open run unless held up.
// An entry passes the command queue, the draw stage and the output register.
// Throughput: one entry per cycle unless stalled; an entry that breaks the open
// run and ends the list stays at the head; the back makes one draw per cycle.
// Reset (synchronous, active low) closes the open run, empties the queue and
// zeroes both registers. While i_stall holds, o_data stays put, the draw stage
// and queue fill behind it, and o_stall rises once the queue is full.
module sorted_triangle_run_coalescer
    import stc_pkg::*;
#(
    parameter int INDEX_CAPACITY = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_I_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  t_in_item           i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out_item          o_data
);

    t_cmd    cmd;
    t_q_head head;
    logic    q_full;
    logic    q_pop;

    // front end
    stc_front #(
        .INDEX_CAPACITY(INDEX_CAPACITY)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_data),
        .o_cmd      (cmd)
    );

    // command queue
    stc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_valid && !q_full),
        .i_cmd  (cmd),
        .o_full (q_full),
        .o_head (head),
        .i_pop  (q_pop)
    );

    // back end
    stc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (head),
        .o_pop  (q_pop),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    assign o_stall = q_full;

endmodule

/* hdl/stc_checker.sv */
// port-level checker for the sorted triangle run coalescer, with its bind
module stc_checker
    import stc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      o_stall,
    input logic      i_stall,
    input t_out_item o_data
);

    // reset leaves no draw pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("draw or stall present after reset");

    // every emitted run holds at least one triangle
    a_nonzero_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.draw_triangles != '0)
        else $error("draw with no triangles");

    // a stalled draw is not withdrawn
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("draw dropped while stalled");

    // a stalled draw keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("draw payload changed while stalled");

endmodule

bind sorted_triangle_run_coalescer stc_checker u_stc_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .o_stall(o_stall),
    .i_stall(i_stall),
    .o_data (o_data)
);

/* tb/sv/tb_top.sv */
// testbench for the sorted triangle run coalescer: directed and random entry lists, scored draws
module tb_top;
    import stc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned INDEX_CAP    = 65536;
    localparam int          DRAIN_CYCLES = 12;

    // register indices that the block must ignore
    localparam logic [CFG_I_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_I_W-1:0] CFG_SPARE_B = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CFG_I_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    t_in_item           i_data      = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    t_out_item          o_data;

    // entries waiting to be sent and draws waiting to be seen
    t_in_item  entry_q [$];
    t_out_item draw_q [$];

    // register and run state of the prediction
    logic [CFG_W-1:0] cfg_total = '0;
    logic [CFG_W-1:0] cfg_mats  = '0;
    logic             run_open  = 1'b0;
    logic [MAT_W-1:0] run_mat   = '0;
    int unsigned      run_first = 0;
    int unsigned      run_len   = 0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    logic in_taken    = 1'b0;

    int err_count     = 0;
    int entries_sent  = 0;
    int draws_checked = 0;
    int settings_used = 0;

    sorted_triangle_run_coalescer #(
        .INDEX_CAPACITY(INDEX_CAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // queue the open run as an expected draw
    function automatic void emit_run(input logic last);
        t_out_item d;
        d.draw_material  = run_mat;
        d.draw_first     = run_first[IDX_W-1:0];
        d.draw_triangles = TRI_W'(run_len / TRI_INDICES);
        d.last_draw      = last;
        draw_q.insert(draw_q.size(), d);
    endfunction

    // classify one entry and merge it into, or break, the open run
    function automatic void coalesce_entry(input t_in_item e);
        int unsigned lim;
        logic ok;
        lim = (cfg_total > INDEX_CAP) ? INDEX_CAP : cfg_total;
        ok = (e.index_count >= TRI_INDICES)
          && (int'(e.first_index) + int'(e.index_count) <= lim)
          && (int'(e.material) < int'(cfg_mats));
        if (!ok) begin
            // dropped entry still closes an open run
            if (run_open) begin
                emit_run(e.end_of_list);
                run_open = 1'b0;
            end
            return;
        end
        if (run_open && e.material == run_mat && e.first_index == run_first + run_len) begin
            run_len += e.index_count;
        end else begin
            if (run_open)
                emit_run(1'b0);
            run_open  = 1'b1;
            run_mat   = e.material;
            run_first = e.first_index;
            run_len   = e.index_count;
        end
        if (e.end_of_list) begin
            emit_run(1'b1);
            run_open = 1'b0;
        end
    endfunction

    // input side: present the next entry, hold it while stalled; random receiver stall
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (entry_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    i_data  <= entry_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // output side: score each draw transfer, then predict from each entry transfer
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken = i_rst_n && i_valid && !o_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            if (draw_q.size() == 0) begin
                flag_error($sformatf("draw with none expected: %p", o_data));
            end else begin
                want = draw_q.pop_front();
                if (o_data.draw_material !== want.draw_material)
                    flag_error($sformatf("draw %0d material %0d, expected %0d", draws_checked,
                                         o_data.draw_material, want.draw_material));
                if (o_data.draw_first !== want.draw_first)
                    flag_error($sformatf("draw %0d first %0d, expected %0d", draws_checked,
                                         o_data.draw_first, want.draw_first));
                if (o_data.draw_triangles !== want.draw_triangles)
                    flag_error($sformatf("draw %0d triangles %0d, expected %0d", draws_checked,
                                         o_data.draw_triangles, want.draw_triangles));
                if (o_data.last_draw !== want.last_draw)
                    flag_error($sformatf("draw %0d last %0b, expected %0b", draws_checked,
                                         o_data.last_draw, want.last_draw));
            end
            draws_checked++;
        end
        if (in_taken) begin
            coalesce_entry(i_data);
            entries_sent++;
        end
    end

    task automatic add_entry(input int unsigned first, input int unsigned count,
                             input int unsigned mat, input logic eol);
        t_in_item e;
        e.first_index = first[IDX_W-1:0];
        e.index_count = count[CNT_W-1:0];
        e.material    = mat[MAT_W-1:0];
        e.end_of_list = eol;
        entry_q.insert(entry_q.size(), e);
    endtask

    // wait until every entry is sent and every draw has come, then let the pipe empty
    task automatic settle();
        while (entry_q.size() > 0 || i_valid || draw_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (draw_q.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_INDEX_TOTAL)
            cfg_total = val[CFG_W-1:0];
        else if (idx == CFG_MATERIAL_COUNT)
            cfg_mats = val[CFG_W-1:0];
    endtask

    task automatic set_regs(input int unsigned total, input int unsigned mats,
                            input int send_pct, input int rx_pct);
        settle();
        write_reg(CFG_INDEX_TOTAL, total);
        write_reg(CFG_MATERIAL_COUNT, mats);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
        settings_used++;
    endtask

    // sorted lists of contiguous runs with some gaps, material changes and broken entries
    task automatic gen_lists(input int n);
        int unsigned lim, mc, pos, cnt;
        int made, k, r, j;
        logic [MAT_W-1:0] pool [3];
        logic [MAT_W-1:0] mat;
        t_in_item e;
        lim  = (cfg_total > INDEX_CAP) ? INDEX_CAP : cfg_total;
        mc   = (cfg_mats > INDEX_CAP) ? INDEX_CAP : cfg_mats;
        made = 0;
        while (made < n) begin
            for (j = 0; j < 3; j++)
                pool[j] = MAT_W'((mc > 0) ? $urandom_range(mc - 1, 0) : $urandom);
            mat = pool[0];
            pos = (lim > 0) ? $urandom_range(lim - 1, 0) : $urandom_range(INDEX_CAP - 1, 0);
            // sometimes start right against the index total
            if (lim > 64 && $urandom_range(7, 0) == 0)
                pos = lim - $urandom_range(64, 3);
            k = $urandom_range(12, 1);
            for (j = 0; j < k; j++) begin
                r   = $urandom_range(99, 0);
                cnt = ($urandom_range(19, 0) == 0) ? $urandom_range(4000, 3)
                                                   : $urandom_range(40, 3);
                if (r < 15)
                    pos += $urandom_range(20, 1);
                else if (r < 30)
                    mat = pool[$urandom_range(2, 0)];
                e.first_index = pos[IDX_W-1:0];
                e.index_count = cnt[CNT_W-1:0];
                e.material    = mat;
                e.end_of_list = (j == k - 1);
                if (r >= 92) begin
                    // noise entry
                    e.first_index = IDX_W'($urandom);
                    e.index_count = CNT_W'($urandom);
                    e.material    = MAT_W'($urandom);
                    e.end_of_list = e.end_of_list | ($urandom_range(15, 0) == 0);
                end else if (r >= 86) begin
                    // broken entry
                    case ($urandom_range(2, 0))
                        0: begin
                            e.index_count = CNT_W'($urandom_range(2, 0));
                        end
                        1: begin
                            if (mc < INDEX_CAP)
                                e.material = MAT_W'($urandom_range(INDEX_CAP - 1, mc));
                            else
                                e.index_count = CNT_W'($urandom_range(2, 0));
                        end
                        default: begin
                            e.index_count = CNT_W'(((lim > pos) ? lim - pos : 0)
                                                   + $urandom_range(5, 1));
                        end
                    endcase
                end else begin
                    pos += cnt;
                end
                entry_q.insert(entry_q.size(), e);
                made++;
            end
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: nothing is valid, no draws
        add_entry(0, 3, 0, 1'b0);
        add_entry(10, 6, 1, 1'b1);

        // directed runs over the full index range
        set_regs(INDEX_CAP, INDEX_CAP, 0, 0);
        add_entry(0, 3, 5, 1'b0);
        add_entry(3, 6, 5, 1'b0);            // contiguous merge
        add_entry(9, 3, 6, 1'b0);            // material change
        add_entry(12, 3, 6, 1'b0);
        add_entry(20, 4, 6, 1'b0);           // gap breaks the run
        add_entry(24, 2, 6, 1'b0);           // short count closes the run
        add_entry(30, 1, 6, 1'b1);           // end of list, invalid, nothing open
        add_entry(0, 0, 0, 1'b0);
        add_entry(100, 5, 7, 1'b0);
        add_entry(105, 131071, 7, 1'b1);     // oversized count ends the list
        add_entry(0, INDEX_CAP, 65535, 1'b1); // whole index range, top material
        add_entry(65533, 3, 65535, 1'b0);
        add_entry(65535, 3, 3, 1'b1);        // runs past the end, closes with last set
        add_entry(40, 7, 2, 1'b0);
        add_entry(50, 8, 2, 1'b1);           // break and end of list together
        add_entry(60, 3, 4, 1'b0);
        add_entry(63, 4, 4, 1'b1);           // merge on end of list
        gen_lists(320);

        // few materials, small index space, idle sender
        set_regs(2000, 8, 55, 0);
        add_entry(0, 3, 8, 1'b1);            // material out of range, nothing open
        add_entry(0, 3, 7, 1'b0);
        add_entry(3, 3, 8, 1'b1);            // material out of range closes with last set
        gen_lists(300);

        // both registers beyond capacity, stalling receiver, with a full drain midway
        set_regs(131071, 131071, 0, 55);
        add_entry(65530, 6, 100, 1'b1);      // ends exactly at the capped total
        add_entry(65530, 7, 100, 1'b1);
        gen_lists(150);
        settle();
        gen_lists(150);

        // one material only; writes to unused indices must not change anything
        set_regs(65537, 1, 6, 6);
        write_reg(CFG_SPARE_A, 0);
        write_reg(CFG_SPARE_B, 0);
        gen_lists(300);

        // tight total and material count
        set_regs(300, 3, 0, 0);
        gen_lists(250);

        // both registers zero: every entry dropped
        set_regs(0, 0, 0, 0);
        gen_lists(30);

        settle();
        if (draw_q.size() != 0)
            flag_error($sformatf("%0d draws never arrived", draw_q.size()));
        $display("covered %0d entries and %0d draws under %0d register settings",
                 entries_sent, draws_checked, settings_used);
        if (err_count == 0)
            $display("sorted_triangle_run_coalescer test passed");
        else
            $display("sorted_triangle_run_coalescer test failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d draws outstanding", draw_q.size());
        $display("sorted_triangle_run_coalescer test failed");
        $finish;
    end

endmodule
